// ===== rtl/atss_pkg.sv =====
// ----------------------------------------------------------------------------
// atss_pkg: shared types and constants for the aspect target selector
// Field widths, reset values, register indexes, turret commands and the
// reciprocal used for the offset scaling.
// ----------------------------------------------------------------------------
package atss_pkg;

  // Field widths of the particle report and the frame result.
  localparam int BOX_W_BITS  = 10;
  localparam int BOX_H_BITS  = 9;
  localparam int CX_BITS     = 10;
  localparam int INDEX_BITS  = 8;
  localparam int OFFSET_BITS = 10;
  localparam int CMD_BITS    = 2;
  localparam int CFG_BITS    = 10;
  localparam int DIST_BITS   = 12;

  // Default frame capacity.
  localparam int MAX_PARTICLES_DEF = 256;

  // Register file.
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RST = 10'd320;
  localparam logic [CFG_BITS-1:0] MARGIN_RST      = 10'd16;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH = 1'b0,
    REG_MARGIN      = 1'b1
  } reg_idx_t;

  // Turret commands.
  typedef enum logic [CMD_BITS-1:0] {
    CMD_HOLD  = 2'd0,
    CMD_LEFT  = 2'd1,
    CMD_RIGHT = 2'd2
  } cmd_t;

  // Division by 47 as a multiply by ceil(2^21/47) and a shift. The scaled
  // magnitude is below 2^15, where this gives the exact floor quotient.
  localparam int MAG_BITS    = 15;
  localparam int RECIP_BITS  = 16;
  localparam int RECIP_SHIFT = 21;
  localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;
  localparam int QUOT_BITS   = PROD_BITS - RECIP_SHIFT;
  localparam logic [RECIP_BITS-1:0] RECIP_47 = 16'd44621;

  // Frame result handed from the selector to the offset stage.
  typedef struct packed {
    logic [INDEX_BITS-1:0] pos;
    logic [CX_BITS-1:0]    center;
    logic                  found;
  } frame_res_t;

endpackage

// ===== rtl/atss_if.sv =====
// ----------------------------------------------------------------------------
// atss_if: request channels of the aspect target selector
// Particle report channel and frame result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface atss_in_if;
  import atss_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [BOX_W_BITS-1:0] box_width;
  logic [BOX_H_BITS-1:0] box_height;
  logic [CX_BITS-1:0]    center_x;
  logic                  last_particle;
  logic                  empty_frame;

  modport source (
    output valid, box_width, box_height, center_x, last_particle, empty_frame,
    input  ready
  );
  modport sink (
    input  valid, box_width, box_height, center_x, last_particle, empty_frame,
    output ready
  );
endinterface

interface atss_out_if;
  import atss_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [INDEX_BITS-1:0]         best_index;
  logic signed [OFFSET_BITS-1:0] offset_q4;
  logic [CMD_BITS-1:0]           command;
  logic                          found;

  modport source (
    output valid, best_index, offset_q4, command, found,
    input  ready
  );
  modport sink (
    input  valid, best_index, offset_q4, command, found,
    output ready
  );
endinterface

// ===== rtl/atss_cfg.sv =====
// ----------------------------------------------------------------------------
// atss_cfg: configuration registers
// APB-style register file holding the image width and the steering margin.
// ----------------------------------------------------------------------------
module atss_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [atss_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [atss_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [atss_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output logic [atss_pkg::CFG_BITS-1:0]      image_width,
  output logic [atss_pkg::CFG_BITS-1:0]      margin_q4
);
  import atss_pkg::*;

  logic [CFG_BITS-1:0] image_width_r;
  logic [CFG_BITS-1:0] margin_r;
  reg_idx_t            reg_idx;

  assign reg_idx     = reg_idx_t'(paddr[2]);
  assign pready      = 1'b1;
  assign image_width = image_width_r;
  assign margin_q4   = margin_r;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMAGE_WIDTH_RST;
      margin_r      <= MARGIN_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH: image_width_r <= pwdata[CFG_BITS-1:0];
        REG_MARGIN:      margin_r      <= pwdata[CFG_BITS-1:0];
      endcase
    end
  end

  // Read data decode.
  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH: prdata = APB_DATA_BITS'(image_width_r);
      REG_MARGIN:      prdata = APB_DATA_BITS'(margin_r);
    endcase
  end

endmodule

// ===== rtl/atss_select.sv =====
// ----------------------------------------------------------------------------
// atss_select: particle selection
// Registers each particle report, compares its aspect distance against the
// stored best by cross-multiplication and hands a frame result onward.
// ----------------------------------------------------------------------------
module atss_select #(
  parameter int MAX_PARTICLES = atss_pkg::MAX_PARTICLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  atss_in_if.sink              in_bus,
  output logic                 res_valid,
  input  logic                 res_ready,
  output atss_pkg::frame_res_t res
);
  import atss_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_PARTICLES + 1);
  localparam int PRODUCT_BITS = DIST_BITS + BOX_H_BITS;

  // Input register.
  logic                  s1_valid_r;
  logic [BOX_W_BITS-1:0] s1_w_r;
  logic [BOX_H_BITS-1:0] s1_h_r;
  logic [CX_BITS-1:0]    s1_cx_r;
  logic                  s1_last_r;
  logic                  s1_empty_r;

  // Frame state.
  logic [CNT_BITS-1:0]   cnt_r;
  logic [INDEX_BITS-1:0] best_pos_r;
  logic [DIST_BITS-1:0]  best_dist_r;
  logic [BOX_H_BITS-1:0] best_h_r;
  logic [CX_BITS-1:0]    best_cx_r;

  // Result register.
  logic       res_valid_r;
  frame_res_t res_r;

  logic                    frame_end;
  logic                    res_free;
  logic                    s1_done;
  logic                    res_load;
  logic [DIST_BITS-1:0]    dist_a;
  logic [DIST_BITS-1:0]    dist_b;
  logic [DIST_BITS-1:0]    dist_abs;
  logic [PRODUCT_BITS-1:0] prod_best;
  logic [PRODUCT_BITS-1:0] prod_new;
  logic                    in_range;
  logic                    take;
  logic                    keep;
  logic [INDEX_BITS-1:0]   pos_new;
  logic [CX_BITS-1:0]      cx_new;

  // Handshake: a frame end waits for room in the result register.
  assign frame_end     = s1_last_r || s1_empty_r;
  assign res_free      = !res_valid_r || res_ready;
  assign s1_done       = s1_valid_r && (!frame_end || res_free);
  assign res_load      = s1_done && frame_end;
  assign in_bus.ready  = !s1_valid_r || s1_done;
  assign res_valid     = res_valid_r;
  assign res           = res_r;

  // Aspect distance |3w - 4h| and the cross products.
  always_comb begin
    dist_a    = DIST_BITS'({s1_w_r, 1'b0}) + DIST_BITS'(s1_w_r);
    dist_b    = DIST_BITS'({s1_h_r, 2'b00});
    dist_abs  = (dist_a >= dist_b) ? (dist_a - dist_b) : (dist_b - dist_a);
    prod_best = PRODUCT_BITS'(best_dist_r) * PRODUCT_BITS'(s1_h_r);
    prod_new  = PRODUCT_BITS'(dist_abs) * PRODUCT_BITS'(best_h_r);
  end

  // Keep decision; a zero height ranks worst and ties go to the newer one.
  always_comb begin
    in_range = cnt_r < CNT_BITS'(MAX_PARTICLES);
    if (cnt_r == '0) begin
      take = 1'b1;
    end else if (s1_h_r == '0) begin
      take = (best_h_r == '0);
    end else if (best_h_r == '0) begin
      take = 1'b1;
    end else begin
      take = prod_best >= prod_new;
    end
    keep    = in_range && take;
    pos_new = keep ? INDEX_BITS'(cnt_r) : best_pos_r;
    cx_new  = keep ? s1_cx_r : best_cx_r;
  end

  // Input register load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_w_r     <= in_bus.box_width;
      s1_h_r     <= in_bus.box_height;
      s1_cx_r    <= in_bus.center_x;
      s1_last_r  <= in_bus.last_particle;
      s1_empty_r <= in_bus.empty_frame;
    end
  end

  // Frame state update; a frame end clears it for the next frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      best_pos_r  <= '0;
      best_dist_r <= '0;
      best_h_r    <= '0;
      best_cx_r   <= '0;
    end else if (s1_done) begin
      if (frame_end) begin
        cnt_r       <= '0;
        best_pos_r  <= '0;
        best_dist_r <= '0;
        best_h_r    <= '0;
        best_cx_r   <= '0;
      end else if (in_range) begin
        cnt_r <= cnt_r + 1'b1;
        if (take) begin
          best_pos_r  <= pos_new;
          best_dist_r <= dist_abs;
          best_h_r    <= s1_h_r;
          best_cx_r   <= s1_cx_r;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_load) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r.found  <= !s1_empty_r;
      res_r.pos    <= s1_empty_r ? '0 : pos_new;
      res_r.center <= s1_empty_r ? '0 : cx_new;
    end
  end

endmodule

// ===== rtl/atss_offset.sv =====
// ----------------------------------------------------------------------------
// atss_offset: offset scaling and turret command
// Scales (2*cx - image_width) by 16/47 with truncation toward zero,
// saturates it and derives the turret command from the margin.
// ----------------------------------------------------------------------------
module atss_offset (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          res_valid,
  output logic                          res_ready,
  input  atss_pkg::frame_res_t          res,
  input  logic [atss_pkg::CFG_BITS-1:0] image_width,
  input  logic [atss_pkg::CFG_BITS-1:0] margin_q4,
  atss_out_if.source                    out_bus
);
  import atss_pkg::*;

  localparam int DIFF_BITS = CX_BITS + 2;
  localparam int ABS_BITS  = DIFF_BITS - 1;
  localparam int SOFF_BITS = QUOT_BITS + 1;
  localparam int CMP_BITS  = CFG_BITS + 2;
  localparam logic signed [SOFF_BITS-1:0] OFF_MAX = SOFF_BITS'(2**(OFFSET_BITS-1) - 1);
  localparam logic signed [SOFF_BITS-1:0] OFF_MIN = -SOFF_BITS'(2**(OFFSET_BITS-1));

  // Product register.
  logic                  s3_valid_r;
  logic [PROD_BITS-1:0]  s3_prod_r;
  logic                  s3_neg_r;
  logic [INDEX_BITS-1:0] s3_pos_r;
  logic                  s3_found_r;

  // Output register.
  logic                          out_valid_r;
  logic [INDEX_BITS-1:0]         out_index_r;
  logic signed [OFFSET_BITS-1:0] out_offset_r;
  cmd_t                          out_cmd_r;
  logic                          out_found_r;

  logic                        out_free;
  logic                        s3_free;
  logic                        s3_move;
  logic signed [DIFF_BITS-1:0] diff;
  logic                        neg;
  logic [ABS_BITS-1:0]         abs_diff;
  logic [MAG_BITS-1:0]         mag;
  logic [PROD_BITS-1:0]        prod;
  logic [QUOT_BITS-1:0]        quot;
  logic signed [SOFF_BITS-1:0] off_full;
  logic signed [SOFF_BITS-1:0] off_sat;
  logic signed [CMP_BITS-1:0]  off_cmp;
  logic signed [CMP_BITS-1:0]  marg;
  cmd_t                        cmd;

  // Stage handshake.
  assign out_free  = !out_valid_r || out_bus.ready;
  assign s3_free   = !s3_valid_r || out_free;
  assign s3_move   = s3_valid_r && out_free;
  assign res_ready = s3_free;

  // Signed pixel offset, its magnitude times 16, and the reciprocal product.
  always_comb begin
    diff     = $signed({1'b0, res.center, 1'b0}) - $signed(DIFF_BITS'(image_width));
    neg      = res.found && diff[DIFF_BITS-1];
    abs_diff = diff[DIFF_BITS-1] ? ABS_BITS'(-diff) : ABS_BITS'(diff);
    mag      = res.found ? {abs_diff, 4'b0000} : '0;
    prod     = PROD_BITS'(mag) * PROD_BITS'(RECIP_47);
  end

  // Quotient, sign, saturation and the steering compare.
  always_comb begin
    quot     = s3_prod_r[PROD_BITS-1:RECIP_SHIFT];
    off_full = s3_neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    if (off_full > OFF_MAX) begin
      off_sat = OFF_MAX;
    end else if (off_full < OFF_MIN) begin
      off_sat = OFF_MIN;
    end else begin
      off_sat = off_full;
    end
    off_cmp = CMP_BITS'(off_sat);
    marg    = $signed(CMP_BITS'(margin_q4));
    cmd     = CMD_HOLD;
    if (off_cmp >= marg) begin
      cmd = CMD_LEFT;
    end
    if (off_cmp <= -marg) begin
      cmd = CMD_RIGHT;
    end
  end

  // Product register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_free) begin
      s3_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && s3_free) begin
      s3_prod_r  <= prod;
      s3_neg_r   <= neg;
      s3_pos_r   <= res.pos;
      s3_found_r <= res.found;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_move) begin
      out_index_r  <= s3_pos_r;
      out_offset_r <= OFFSET_BITS'(off_sat);
      out_cmd_r    <= cmd;
      out_found_r  <= s3_found_r;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.best_index = out_index_r;
  assign out_bus.offset_q4  = out_offset_r;
  assign out_bus.command    = out_cmd_r;
  assign out_bus.found      = out_found_r;

endmodule

// ===== rtl/aspect_target_select_steer.sv =====
// ----------------------------------------------------------------------------
// aspect_target_select_steer: aspect-ratio target selector with steering
// Keeps the particle of a frame closest to a 4:3 aspect ratio and reports
// its index, its scaled horizontal offset and a turret command.
//
//   channel   direction  request
//   in_bus    sink       one particle report, or an empty-frame marker
//   out_bus   source     one frame result, on a last particle or empty frame
//   psel...   APB slave  image_width at 0x0, margin_q4 at 0x4
//
// One particle report is accepted every cycle unless a frame end waits; the
// loop through the stored best (two 12x9 cross products and a compare) is
// combinational. A frame result passes the input, result, product and output
// registers. Reset is synchronous and clears the frame state and all valid
// flags; no memory sweep follows it. A stall on out_bus fills the result
// stages and then holds in_bus ready low only while a frame end is waiting.
// ----------------------------------------------------------------------------
module aspect_target_select_steer #(
  parameter int MAX_PARTICLES = atss_pkg::MAX_PARTICLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  atss_in_if.sink                            in_bus,
  atss_out_if.source                         out_bus,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [atss_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [atss_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [atss_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import atss_pkg::*;

  logic [CFG_BITS-1:0] image_width;
  logic [CFG_BITS-1:0] margin_q4;
  logic                res_valid;
  logic                res_ready;
  frame_res_t          res;

  // Configuration registers.
  atss_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .image_width (image_width),
    .margin_q4   (margin_q4)
  );

  // Best-particle selection per frame.
  atss_select #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Offset scaling and turret command.
  atss_offset u_offset (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .image_width (image_width),
    .margin_q4   (margin_q4),
    .out_bus     (out_bus)
  );

endmodule

// ===== rtl/atss_checker.sv =====
// ----------------------------------------------------------------------------
// atss_checker: port-level checks for the aspect target selector
// Watches the result channel and checks reset, stall and result rules.
// ----------------------------------------------------------------------------
module atss_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [atss_pkg::INDEX_BITS-1:0]      out_best_index,
  input logic signed [atss_pkg::OFFSET_BITS-1:0] out_offset_q4,
  input logic [atss_pkg::CMD_BITS-1:0]        out_command,
  input logic                                 out_found
);
  import atss_pkg::*;

  // No result is offered right after a reset cycle.
  a_reset_quiet: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result offered right after reset");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_index) &&
      $stable(out_offset_q4) && $stable(out_command) && $stable(out_found))
    else $error("stalled result changed");

  // An empty frame reports index zero and offset zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_best_index == '0 && out_offset_q4 == '0)
    else $error("empty frame result not zero");

  // A centered target never steers left: a zero margin makes right win.
  a_center_no_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_offset_q4 == '0 |-> out_command != CMD_LEFT)
    else $error("zero offset commanded move left");

endmodule

bind aspect_target_select_steer atss_checker u_atss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_best_index (out_bus.best_index),
  .out_offset_q4  (out_bus.offset_q4),
  .out_command    (out_bus.command),
  .out_found      (out_bus.found)
);

// ===== sim/tb_aspect_target_select_steer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aspect_target_select_steer: testbench for the aspect target selector
// Streams particle frames into the block, predicts each frame's chosen index,
// offset and turret command, and compares every frame result in order.
// The register port is exercised with read-back, and both handshakes see
// random idle bursts during most of the run.
// ----------------------------------------------------------------------------
module tb_aspect_target_select_steer;
  import atss_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;

  // One particle report as it travels on the request channel.
  typedef struct packed {
    logic [BOX_W_BITS-1:0] box_width;
    logic [BOX_H_BITS-1:0] box_height;
    logic [CX_BITS-1:0]    center_x;
    logic                  last_particle;
    logic                  empty_frame;
  } report_t;

  // One frame result as the selector should report it.
  typedef struct packed {
    logic [INDEX_BITS-1:0]         best_index;
    logic signed [OFFSET_BITS-1:0] offset_q4;
    cmd_t                          command;
    logic                          found;
  } frame_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  atss_in_if  report_bus ();
  atss_out_if result_bus ();

  aspect_target_select_steer u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (report_bus),
    .out_bus (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the registers and of the frame tracking state.
  logic [CFG_BITS-1:0]   cfg_image_width;
  logic [CFG_BITS-1:0]   cfg_margin;
  int                    seen_particles;
  logic [INDEX_BITS-1:0] best_pos;
  logic [DIST_BITS-1:0]  best_dist;
  logic [BOX_H_BITS-1:0] best_height;
  logic [CX_BITS-1:0]    best_center;

  frame_result_t frame_results[$];
  int            fail_count  = 0;
  int            cycle_count = 0;
  bit            sender_idle_on = 1'b1;
  bit            sink_stall_on  = 1'b1;

  // Clock: 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_aspect_target_select_steer: FAIL");
      $finish;
    end
  end

  function automatic void clear_frame_state();
    seen_particles = 0;
    best_pos       = '0;
    best_dist      = '0;
    best_height    = '0;
    best_center    = '0;
  endfunction

  // Left when the offset reaches the margin, right when it reaches minus the
  // margin; right takes precedence when both are true.
  function automatic cmd_t turret_command(input int offset);
    cmd_t cmd;
    cmd = CMD_HOLD;
    if (offset >= int'(cfg_margin)) cmd = CMD_LEFT;
    if (offset <= -int'(cfg_margin)) cmd = CMD_RIGHT;
    return cmd;
  endfunction

  // Updates the tracked best particle with one report. Returns 1 when the
  // report ends a frame, with the frame's result in res.
  function automatic bit select_target(input report_t rep, output frame_result_t res);
    int  ratio_dist;
    int  offset;
    bit  take;
    res = '0;
    if (rep.empty_frame) begin
      clear_frame_state();
      res.command = turret_command(0);
      return 1'b1;
    end
    if (seen_particles < MAX_PARTICLES_DEF) begin
      ratio_dist = 3 * int'(rep.box_width) - 4 * int'(rep.box_height);
      if (ratio_dist < 0) ratio_dist = -ratio_dist;
      // Cross-multiplied ratio compare; a zero height is the worst distance.
      if (seen_particles == 0) take = 1'b1;
      else if (rep.box_height == 0) take = (best_height == 0);
      else if (best_height == 0) take = 1'b1;
      else take = int'(best_dist) * int'(rep.box_height) >= ratio_dist * int'(best_height);
      if (take) begin
        best_pos    = seen_particles[INDEX_BITS-1:0];
        best_dist   = ratio_dist[DIST_BITS-1:0];
        best_height = rep.box_height;
        best_center = rep.center_x;
      end
      seen_particles++;
    end
    if (!rep.last_particle) return 1'b0;
    // Division truncates toward zero, then the offset saturates.
    offset = (16 * (2 * int'(best_center) - int'(cfg_image_width))) / 47;
    if (offset > 511) offset = 511;
    if (offset < -512) offset = -512;
    res.best_index = best_pos;
    res.offset_q4  = offset[OFFSET_BITS-1:0];
    res.command    = turret_command(offset);
    res.found      = 1'b1;
    clear_frame_state();
    return 1'b1;
  endfunction

  // Predicts at each accepted request and checks each accepted result.
  always @(posedge clk) begin : check_results
    report_t       rep;
    frame_result_t pred;
    frame_result_t want;
    if (rst_n) begin
      if (report_bus.valid && report_bus.ready) begin
        rep = '{report_bus.box_width, report_bus.box_height, report_bus.center_x,
                report_bus.last_particle, report_bus.empty_frame};
        if (select_target(rep, pred)) frame_results.push_back(pred);
      end
      if (result_bus.valid && result_bus.ready) begin
        if (frame_results.size() == 0) begin
          $error("frame result with no request pending: index %0d offset %0d",
                 result_bus.best_index, result_bus.offset_q4);
          fail_count++;
        end else begin
          want = frame_results.pop_front();
          if (result_bus.best_index !== want.best_index) begin
            $error("best_index mismatch: expected %0d, got %0d",
                   want.best_index, result_bus.best_index);
            fail_count++;
          end
          if (result_bus.offset_q4 !== want.offset_q4) begin
            $error("offset_q4 mismatch: expected %0d, got %0d",
                   want.offset_q4, result_bus.offset_q4);
            fail_count++;
          end
          if (result_bus.command !== want.command) begin
            $error("command mismatch: expected %0d, got %0d",
                   want.command, result_bus.command);
            fail_count++;
          end
          if (result_bus.found !== want.found) begin
            $error("found mismatch: expected %0d, got %0d",
                   want.found, result_bus.found);
            fail_count++;
          end
        end
      end
    end
  end

  // Result side back-pressure: random stall bursts between ready stretches.
  initial begin
    result_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_stall_on && $urandom_range(0, 3) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat (200) @(posedge clk);
      else repeat ($urandom_range(1, 25)) @(posedge clk);
    end
  end

  function automatic report_t particle(input int w, input int h, input int cx,
                                       input bit last_flag);
    report_t rep;
    rep.box_width     = w[BOX_W_BITS-1:0];
    rep.box_height    = h[BOX_H_BITS-1:0];
    rep.center_x      = cx[CX_BITS-1:0];
    rep.last_particle = last_flag;
    rep.empty_frame   = 1'b0;
    return rep;
  endfunction

  // Empty-frame marker with junk in the ignored fields.
  function automatic report_t empty_marker();
    report_t rep;
    rep = particle($urandom_range(0, 1023), $urandom_range(0, 511),
                   $urandom_range(0, 1023), $urandom_range(0, 1));
    rep.empty_frame = 1'b1;
    return rep;
  endfunction

  // Random particle, close to a 4:3 box in two draws of five so the selection is contested.
  function automatic report_t random_particle(input bit last_flag);
    int mode;
    int w;
    int h;
    int cx;
    mode = $urandom_range(0, 99);
    if (mode < 40) begin
      h = $urandom_range(1, 480);
      w = (4 * h) / 3 + $urandom_range(0, 6) - 3;
      if (w < 0) w = 0;
    end else if (mode < 55) begin
      h = 0;
      w = $urandom_range(0, 640);
    end else if (mode < 80) begin
      h = $urandom_range(0, 511);
      w = $urandom_range(0, 1023);
    end else begin
      h = $urandom_range(0, 480);
      w = $urandom_range(0, 640);
    end
    cx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 639) : $urandom_range(0, 1023);
    return particle(w, h, cx, last_flag);
  endfunction

  // Sends one request, after an optional idle burst. valid stays high on
  // return so that back-to-back requests follow without a gap.
  task automatic send_report(input report_t rep);
    if (sender_idle_on && $urandom_range(0, 5) == 0) begin
      report_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    report_bus.valid         <= 1'b1;
    report_bus.box_width     <= rep.box_width;
    report_bus.box_height    <= rep.box_height;
    report_bus.center_x      <= rep.center_x;
    report_bus.last_particle <= rep.last_particle;
    report_bus.empty_frame   <= rep.empty_frame;
    do @(posedge clk); while (!report_bus.ready);
  endtask

  // Waits until every expected result is in and the pipeline has settled.
  task automatic wait_idle();
    report_bus.valid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_transfer(input bit is_write, input reg_idx_t idx,
                              input logic [APB_DATA_BITS-1:0] wdata,
                              output logic [APB_DATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input reg_idx_t idx, input logic [CFG_BITS-1:0] value);
    logic [APB_DATA_BITS-1:0] rdata;
    apb_transfer(1'b0, idx, '0, rdata);
    if (rdata !== APB_DATA_BITS'(value)) begin
      $error("register %0d read mismatch: expected %0d, got %0d", idx, value, rdata);
      fail_count++;
    end
  endtask

  // Writes one register while the block is idle and reads it back.
  task automatic program_register(input reg_idx_t idx, input logic [CFG_BITS-1:0] value);
    logic [APB_DATA_BITS-1:0] rdata;
    wait_idle();
    apb_transfer(1'b1, idx, APB_DATA_BITS'(value), rdata);
    case (idx)
      REG_IMAGE_WIDTH: cfg_image_width = value;
      REG_MARGIN:      cfg_margin = value;
    endcase
    check_register(idx, value);
  endtask

  task automatic test_register_defaults();
    check_register(REG_IMAGE_WIDTH, IMAGE_WIDTH_RST);
    check_register(REG_MARGIN, MARGIN_RST);
  endtask

  // Field extremes, zero heights, ties, empty and cut-short frames.
  task automatic test_directed_frames();
    send_report(particle(640, 480, 639, 1'b1));
    send_report(particle(0, 0, 0, 1'b1));
    send_report(particle(1023, 511, 1023, 1'b1));
    // A later zero-height particle replaces a zero-height best.
    send_report(particle(5, 0, 10, 1'b0));
    send_report(particle(7, 0, 20, 1'b1));
    // Any real height beats a zero-height best, but not the other way round.
    send_report(particle(9, 0, 30, 1'b0));
    send_report(particle(40, 30, 300, 1'b1));
    send_report(particle(40, 30, 100, 1'b0));
    send_report(particle(9, 0, 500, 1'b1));
    // Equal ratio distance: the later particle wins.
    send_report(particle(8, 3, 50, 1'b0));
    send_report(particle(16, 6, 600, 1'b1));
    // An exact 4:3 box first, then worse ones.
    send_report(particle(4, 3, 200, 1'b0));
    send_report(particle(100, 10, 10, 1'b0));
    send_report(particle(5, 3, 300, 1'b1));
    send_report(empty_marker());
    // A frame cut short by an empty marker is dropped.
    send_report(particle(30, 20, 400, 1'b0));
    send_report(empty_marker());
    // Centered target inside the dead band.
    send_report(particle(4, 3, 160, 1'b1));
  endtask

  // Margin and image width at their extremes, offset saturation and rounding.
  task automatic test_steering_extremes();
    program_register(REG_MARGIN, 10'd0);
    send_report(empty_marker());
    send_report(particle(4, 3, 160, 1'b1));
    send_report(particle(4, 3, 170, 1'b1));
    send_report(particle(4, 3, 150, 1'b1));
    program_register(REG_IMAGE_WIDTH, 10'd1);
    send_report(particle(4, 3, 0, 1'b1));
    send_report(particle(4, 3, 1023, 1'b1));
    program_register(REG_MARGIN, 10'd1023);
    send_report(particle(4, 3, 1023, 1'b1));
    send_report(empty_marker());
    program_register(REG_IMAGE_WIDTH, 10'd1023);
    program_register(REG_MARGIN, 10'd16);
    send_report(particle(4, 3, 0, 1'b1));
    send_report(particle(4, 3, 1023, 1'b1));
    program_register(REG_IMAGE_WIDTH, 10'd640);
    send_report(particle(4, 3, 639, 1'b1));
    send_report(particle(4, 3, 0, 1'b1));
    send_report(particle(4, 3, 320, 1'b1));
  endtask

  // Particles past the frame capacity take no part in the selection.
  task automatic test_particle_overflow();
    for (int i = 0; i < 300; i++) begin
      if (i == 255) send_report(particle(4, 3, 37, 1'b0));
      else if (i >= 256) send_report(particle(4, 3, 600, i == 299));
      else send_report(particle(100, 10, $urandom_range(0, 639), 1'b0));
    end
  endtask

  // Random frames: mostly well-formed, some empty markers and cut-short frames.
  task automatic run_random_frames(input int n_items);
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        send_report(empty_marker());
        sent++;
      end else if (kind < 11) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) send_report(random_particle(1'b0));
        send_report(empty_marker());
        sent += len + 1;
      end else begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_report(random_particle(i == len - 1));
        sent += len;
      end
    end
  endtask

  task automatic test_random_frames();
    program_register(REG_IMAGE_WIDTH, CFG_BITS'($urandom_range(1, 640)));
    program_register(REG_MARGIN, CFG_BITS'($urandom_range(0, 40)));
    run_random_frames(320);
    program_register(REG_IMAGE_WIDTH, 10'd640);
    program_register(REG_MARGIN, 10'd0);
    run_random_frames(320);
    program_register(REG_IMAGE_WIDTH, 10'd1);
    program_register(REG_MARGIN, CFG_BITS'($urandom_range(0, 1023)));
    run_random_frames(320);
    // Last stretch at full rate on both sides.
    program_register(REG_IMAGE_WIDTH, 10'd320);
    program_register(REG_MARGIN, 10'd16);
    sender_idle_on = 1'b0;
    sink_stall_on  = 1'b0;
    run_random_frames(320);
  endtask

  initial begin
    rst_n                    <= 1'b0;
    report_bus.valid         <= 1'b0;
    report_bus.box_width     <= '0;
    report_bus.box_height    <= '0;
    report_bus.center_x      <= '0;
    report_bus.last_particle <= 1'b0;
    report_bus.empty_frame   <= 1'b0;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    cfg_image_width = IMAGE_WIDTH_RST;
    cfg_margin      = MARGIN_RST;
    clear_frame_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_defaults();
    test_directed_frames();
    test_steering_extremes();
    test_particle_overflow();
    test_random_frames();
    wait_idle();

    if (fail_count == 0) begin
      $display("tb_aspect_target_select_steer: PASS");
    end else begin
      $display("tb_aspect_target_select_steer: FAIL");
    end
    $finish;
  end

endmodule

// ===== aspect_target_select_steer.f =====
rtl/atss_pkg.sv
rtl/atss_if.sv
rtl/atss_cfg.sv
rtl/atss_select.sv
rtl/atss_offset.sv
rtl/aspect_target_select_steer.sv
rtl/atss_checker.sv
sim/tb_aspect_target_select_steer.sv
